### src/lli_pkg.sv
// Shared types and constants for the line crossing pipeline.
package lli_pkg;

  localparam int OUT_W = 32;
  localparam int QBITS = 32;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic found;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

### src/lli_front.sv
// Determinant front end: differences, products, numerators and divider operands.
module lli_front #(
  parameter int C = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [C-1:0]    x1,
  input  logic signed [C-1:0]    y1,
  input  logic signed [C-1:0]    x2,
  input  logic signed [C-1:0]    y2,
  input  logic signed [C-1:0]    x3,
  input  logic signed [C-1:0]    y3,
  input  logic signed [C-1:0]    x4,
  input  logic signed [C-1:0]    y4,
  output logic                   vld,
  output lli_pkg::flags_t        flags,
  output logic [3*C+1:0]         tx,
  output logic [3*C+1:0]         ty,
  output logic [2*C+1:0]         d2
);

  localparam int DW   = C + 1;
  localparam int PW   = 2 * C;
  localparam int DETW = 2 * C + 1;
  localparam int DENW = 2 * C + 2;
  localparam int NW   = 3 * C + 1;
  localparam int TSW  = 3 * C + 3;
  localparam int TW   = 3 * C + 2;

  logic [5:0] v_r;

  // stage 1
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  // stage 2
  logic signed [DETW-1:0] d1_r, d2s_r;
  logic signed [DENW-1:0] qa_r, qb_r;
  logic signed [DW-1:0]   dx1b_r, dy1b_r, dx2b_r, dy2b_r;
  // stage 3
  logic signed [DENW-1:0] den_r;
  logic signed [NW-1:0]   m1_r, m2_r, m3_r, m4_r;
  // stage 4
  logic signed [NW-1:0]   nx_r, ny_r;
  logic                   dneg_r, fnd4_r;
  logic [DENW-1:0]        aden_r;
  // stage 5
  logic signed [TSW-1:0]  tsx_r, tsy_r;
  logic [DENW-1:0]        aden5_r;
  logic                   fnd5_r;
  // stage 6
  logic [TW-1:0]          tx_r, ty_r;
  logic [DENW-1:0]        d2_r;
  lli_pkg::flags_t        fl_r;

  logic signed [NW-1:0] sx, sy;

  assign sx = dneg_r ? -nx_r : nx_r;
  assign sy = dneg_r ? -ny_r : ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= DW'(x1) - DW'(x2);
      dy1_r <= DW'(y1) - DW'(y2);
      dx2_r <= DW'(x3) - DW'(x4);
      dy2_r <= DW'(y3) - DW'(y4);
      pa_r  <= PW'(x1) * PW'(y2);
      pb_r  <= PW'(y1) * PW'(x2);
      pc_r  <= PW'(x3) * PW'(y4);
      pd_r  <= PW'(y3) * PW'(x4);

      d1_r   <= DETW'(pa_r) - DETW'(pb_r);
      d2s_r  <= DETW'(pc_r) - DETW'(pd_r);
      qa_r   <= DENW'(dx1_r) * DENW'(dy2_r);
      qb_r   <= DENW'(dy1_r) * DENW'(dx2_r);
      dx1b_r <= dx1_r;
      dy1b_r <= dy1_r;
      dx2b_r <= dx2_r;
      dy2b_r <= dy2_r;

      den_r <= qa_r - qb_r;
      m1_r  <= NW'(d1_r) * NW'(dx2b_r);
      m2_r  <= NW'(dx1b_r) * NW'(d2s_r);
      m3_r  <= NW'(d1_r) * NW'(dy2b_r);
      m4_r  <= NW'(dy1b_r) * NW'(d2s_r);

      nx_r   <= m1_r - m2_r;
      ny_r   <= m3_r - m4_r;
      dneg_r <= den_r[DENW-1];
      fnd4_r <= (den_r != '0);
      aden_r <= den_r[DENW-1] ? DENW'(-den_r) : DENW'(den_r);

      tsx_r   <= (TSW'(sx) <<< 1) + TSW'({1'b0, aden_r});
      tsy_r   <= (TSW'(sy) <<< 1) + TSW'({1'b0, aden_r});
      aden5_r <= aden_r;
      fnd5_r  <= fnd4_r;

      tx_r        <= tsx_r[TSW-1] ? TW'(-tsx_r) : TW'(tsx_r);
      ty_r        <= tsy_r[TSW-1] ? TW'(-tsy_r) : TW'(tsy_r);
      d2_r        <= aden5_r << 1;
      fl_r.found  <= fnd5_r;
      fl_r.neg_x  <= tsx_r[TSW-1];
      fl_r.neg_y  <= tsy_r[TSW-1];
    end
  end

  assign vld   = v_r[5];
  assign flags = fl_r;
  assign tx    = tx_r;
  assign ty    = ty_r;
  assign d2    = d2_r;

endmodule

### src/lli_div.sv
// Pipelined restoring divider: one quotient bit per stage plus overflow check.
module lli_div #(
  parameter int TW = 62,
  parameter int DW = 42
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [TW-1:0]                 t,
  input  logic [DW-1:0]                 d,
  output logic [lli_pkg::QBITS-1:0]     q,
  output logic                          ovf
);

  localparam int QB = lli_pkg::QBITS;
  localparam int CW = (TW > DW) ? TW : DW;

  logic [DW-1:0] rem_r [0:QB];
  logic [DW-1:0] den_r [0:QB];
  logic [QB-1:0] low_r [0:QB];
  logic [QB-1:0] quo_r [0:QB];
  logic          ovf_r [0:QB];

  logic [CW-1:0] hi;
  logic          big;

  assign hi  = CW'(t >> QB);
  assign big = hi >= CW'(d);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= big ? '0 : DW'(hi);
      den_r[0] <= d;
      low_r[0] <= QB'(t);
      quo_r[0] <= '0;
      ovf_r[0] <= big;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_r[k-1], low_r[k-1][QB-k]};
    assign ge = sh >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(sh - {1'b0, den_r[k-1]}) : DW'(sh);
        den_r[k] <= den_r[k-1];
        low_r[k] <= low_r[k-1];
        quo_r[k] <= quo_r[k-1] | (QB'(ge) << (QB - k));
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign q   = quo_r[QB];
  assign ovf = ovf_r[QB];

endmodule

### src/line_line_intersection.sv
// Top level: crossing point of two lines, determinant form, fully pipelined.
// From input accept to result valid, an item passes the front end stages, the divider stages and the output register.
// Throughput: one item per cycle unless the output stalls; the divider takes one quotient bit per stage.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module line_line_intersection #(
  parameter int COORD_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_first_start_x,
  input  logic signed [COORD_BITS-1:0]       in_first_start_y,
  input  logic signed [COORD_BITS-1:0]       in_first_end_x,
  input  logic signed [COORD_BITS-1:0]       in_first_end_y,
  input  logic signed [COORD_BITS-1:0]       in_second_start_x,
  input  logic signed [COORD_BITS-1:0]       in_second_start_y,
  input  logic signed [COORD_BITS-1:0]       in_second_end_x,
  input  logic signed [COORD_BITS-1:0]       in_second_end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic signed [lli_pkg::OUT_W-1:0]   out_cross_x,
  output logic signed [lli_pkg::OUT_W-1:0]   out_cross_y
);

  localparam int TW  = 3 * COORD_BITS + 2;
  localparam int DW  = 2 * COORD_BITS + 2;
  localparam int LAT = lli_pkg::QBITS + 1;

  logic            en;
  logic            fr_vld;
  lli_pkg::flags_t fr_flags;
  logic [TW-1:0]   fr_tx, fr_ty;
  logic [DW-1:0]   fr_d2;

  logic [lli_pkg::QBITS-1:0] qx, qy;
  logic                      ovx, ovy;

  logic [LAT-1:0]  v_r;
  lli_pkg::flags_t fl_r [0:LAT-1];

  logic                      out_valid_r, out_found_r;
  logic [lli_pkg::OUT_W-1:0] cx_r, cy_r;
  logic [lli_pkg::OUT_W-1:0] cx_nxt, cy_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  lli_front #(.C(COORD_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(in_valid),
    .x1    (in_first_start_x),
    .y1    (in_first_start_y),
    .x2    (in_first_end_x),
    .y2    (in_first_end_y),
    .x3    (in_second_start_x),
    .y3    (in_second_start_y),
    .x4    (in_second_end_x),
    .y4    (in_second_end_y),
    .vld   (fr_vld),
    .flags (fr_flags),
    .tx    (fr_tx),
    .ty    (fr_ty),
    .d2    (fr_d2)
  );

  lli_div #(.TW(TW), .DW(DW)) u_div_x (
    .clk(clk), .en(en), .t(fr_tx), .d(fr_d2), .q(qx), .ovf(ovx)
  );

  lli_div #(.TW(TW), .DW(DW)) u_div_y (
    .clk(clk), .en(en), .t(fr_ty), .d(fr_d2), .q(qy), .ovf(ovy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], fr_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= fr_flags;
      for (int i = 1; i < LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  always_comb begin
    if (!fl_r[LAT-1].found) begin
      cx_nxt = '0;
    end else if (fl_r[LAT-1].neg_x) begin
      cx_nxt = (ovx || qx[lli_pkg::QBITS-1]) ? lli_pkg::SAT_MIN : -qx;
    end else begin
      cx_nxt = (ovx || qx[lli_pkg::QBITS-1]) ? lli_pkg::SAT_MAX : qx;
    end
    if (!fl_r[LAT-1].found) begin
      cy_nxt = '0;
    end else if (fl_r[LAT-1].neg_y) begin
      cy_nxt = (ovy || qy[lli_pkg::QBITS-1]) ? lli_pkg::SAT_MIN : -qy;
    end else begin
      cy_nxt = (ovy || qy[lli_pkg::QBITS-1]) ? lli_pkg::SAT_MAX : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_found_r <= fl_r[LAT-1].found;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

  a_zero_when_parallel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("parallel item with nonzero crossing");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("divider valid chain moved while stalled");

  a_den_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_vld && !fr_flags.found) |-> (fr_d2 == '0))
    else $error("found flag disagrees with denominator");

endmodule
